[rtl/slcm_pkg.sv]
// ----------------------------------------------------------------------------
// slcm_pkg
// Shared types and constants for the skew line closest midpoint core.
// ----------------------------------------------------------------------------
`default_nettype none

package slcm_pkg;

  localparam int unsigned COORD_W = 20;
  localparam int unsigned CHUNK_W = 32;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t a1_x;
    coord_t a1_y;
    coord_t a1_z;
    coord_t a2_x;
    coord_t a2_y;
    coord_t a2_z;
    coord_t b1_x;
    coord_t b1_y;
    coord_t b1_z;
    coord_t b2_x;
    coord_t b2_y;
    coord_t b2_z;
  } in_t;

  typedef struct packed {
    coord_t mid_x;
    coord_t mid_y;
    coord_t mid_z;
    logic   degenerate;
  } out_t;

endpackage

`default_nettype wire

[rtl/skew_line_closest_midpoint_core.sv]
// Pipeline depth is set by the multiplier chunk counts and the quotient width.
// Throughput: one item per cycle, limited only by mid_ready.
// A two-entry output buffer lets the pipeline keep moving while a result waits.
// Reset (synchronous, active high) clears all valid bits and the output buffer.
// ----------------------------------------------------------------------------
// skew_line_closest_midpoint_core
// Midpoint of the shortest segment between two 3D lines, fully pipelined.
// ----------------------------------------------------------------------------
`default_nettype none

module skew_line_closest_midpoint_core (
  input  logic           clk,
  input  logic           rst,
  input  slcm_pkg::in_t  hit,
  input  logic           hit_valid,
  output logic           hit_ready,
  output slcm_pkg::out_t mid,
  output logic           mid_valid,
  input  logic           mid_ready
);

  localparam int W   = slcm_pkg::COORD_W;
  localparam int CH  = slcm_pkg::CHUNK_W;
  localparam int EW  = W + 1;
  localparam int NW  = 2 * W + 3;
  localparam int CXW = 3 * W + 5;
  localparam int NNW = 4 * W + 8;
  localparam int DW  = 4 * W + 8;
  localparam int PW  = 5 * W + 9;
  localparam int QB  = W + 2;
  localparam int QW  = W + 4;
  localparam int SW  = W + 6;

  localparam int CE  = (EW + CH - 1) / CH;
  localparam int CN  = (NW + CH - 1) / CH;
  localparam int CC  = (CXW + CH - 1) / CH;
  localparam int CD  = (DW + CH - 1) / CH;
  localparam int L1  = CE * CE;
  localparam int L2  = (CE * CN > CN * CN) ? CE * CN : CN * CN;
  localparam int L3  = CE * CC;
  localparam int L4  = CD * CE;
  localparam int M1  = L1 + 2;
  localparam int M2  = L2 + 2;
  localparam int M3  = L3 + 2;
  localparam int M4  = L4 + 2;
  localparam int DL  = QB + 3;
  localparam int P_N = 2 + M1;
  localparam int P_C = P_N + M2 + 1;
  localparam int P_D = P_C + M3 + 1;
  localparam int P_P = P_D + M4;
  localparam int P_Q = P_P + DL;
  localparam int TL  = P_Q + 1;

  localparam logic signed [SW-1:0] LO = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};
  localparam logic signed [SW-1:0] HI = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};

  logic en;
  logic [TL:1] vld;

  logic [2:0][W-1:0]   a1, a2, b1, b2;
  logic [2:0][EW-1:0]  e1, e2, w, sab;
  logic [2:0][EW-1:0]  e1n, e2n, e1d, e2d, wd, sabd;
  logic [2:0][NW-1:0]  n, n_next;
  logic                deg, degd;
  logic [2:0][CXW-1:0] c1, c2, c1_next, c2_next;
  logic [2:0][2*NW-1:0] sq;
  logic [NNW-1:0]      nn, nnd;
  logic [2:0][EW+CXW-1:0] pd1, pd2;
  logic signed [DW-1:0] d1, d2;
  logic [2:0][QW-1:0]  q1, q2;
  logic [2:0][W-1:0]   mk;
  slcm_pkg::out_t      res, res_next, buf0, buf1;
  logic [1:0]          cnt;
  logic                push, pop;

  assign a1 = {hit.a1_z, hit.a1_y, hit.a1_x};
  assign a2 = {hit.a2_z, hit.a2_y, hit.a2_x};
  assign b1 = {hit.b1_z, hit.b1_y, hit.b1_x};
  assign b2 = {hit.b2_z, hit.b2_y, hit.b2_x};

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        e1[k]  <= {a2[k][W-1], a2[k]} - {a1[k][W-1], a1[k]};
        e2[k]  <= {b2[k][W-1], b2[k]} - {b1[k][W-1], b1[k]};
        w[k]   <= {b1[k][W-1], b1[k]} - {a1[k][W-1], a1[k]};
        sab[k] <= {a1[k][W-1], a1[k]} + {b1[k][W-1], b1[k]};
      end
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_n
    localparam int K1 = (k + 1) % 3;
    localparam int K2 = (k + 2) % 3;
    logic signed [2*EW-1:0] pa, pb;
    slcm_mul #(.AW(EW), .BW(EW), .LAT(L1)) u_mul_a (
      .clk(clk), .en(en), .a($signed(e1[K1])), .b($signed(e2[K2])), .p(pa));
    slcm_mul #(.AW(EW), .BW(EW), .LAT(L1)) u_mul_b (
      .clk(clk), .en(en), .a($signed(e1[K2])), .b($signed(e2[K1])), .p(pb));
    assign n_next[k] = NW'(pa) - NW'(pb);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n   <= n_next;
      deg <= (n_next == '0);
    end
  end

  slcm_dly #(.WIDTH(6*EW), .DEPTH(M1+1)) u_dly_e (
    .clk(clk), .en(en), .d({e1, e2}), .q({e1n, e2n}));

  for (genvar k = 0; k < 3; k++) begin : g_c
    localparam int K1 = (k + 1) % 3;
    localparam int K2 = (k + 2) % 3;
    logic signed [EW+NW-1:0] pa1, pb1, pa2, pb2;
    logic signed [2*NW-1:0]  ps;
    slcm_mul #(.AW(EW), .BW(NW), .LAT(L2)) u_mul_a1 (
      .clk(clk), .en(en), .a($signed(e1n[K1])), .b($signed(n[K2])), .p(pa1));
    slcm_mul #(.AW(EW), .BW(NW), .LAT(L2)) u_mul_b1 (
      .clk(clk), .en(en), .a($signed(e1n[K2])), .b($signed(n[K1])), .p(pb1));
    slcm_mul #(.AW(EW), .BW(NW), .LAT(L2)) u_mul_a2 (
      .clk(clk), .en(en), .a($signed(e2n[K1])), .b($signed(n[K2])), .p(pa2));
    slcm_mul #(.AW(EW), .BW(NW), .LAT(L2)) u_mul_b2 (
      .clk(clk), .en(en), .a($signed(e2n[K2])), .b($signed(n[K1])), .p(pb2));
    slcm_mul #(.AW(NW), .BW(NW), .LAT(L2)) u_mul_sq (
      .clk(clk), .en(en), .a($signed(n[k])), .b($signed(n[k])), .p(ps));
    assign c1_next[k] = CXW'(pa1) - CXW'(pb1);
    assign c2_next[k] = CXW'(pa2) - CXW'(pb2);
    assign sq[k]      = ps;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1 <= c1_next;
      c2 <= c2_next;
      nn <= NNW'($signed(sq[0])) + NNW'($signed(sq[1])) + NNW'($signed(sq[2]));
    end
  end

  slcm_dly #(.WIDTH(3*EW), .DEPTH(P_C-1)) u_dly_w (
    .clk(clk), .en(en), .d(w), .q(wd));

  for (genvar k = 0; k < 3; k++) begin : g_d
    logic signed [EW+CXW-1:0] pm1, pm2;
    slcm_mul #(.AW(EW), .BW(CXW), .LAT(L3)) u_mul_d1 (
      .clk(clk), .en(en), .a($signed(wd[k])), .b($signed(c2[k])), .p(pm1));
    slcm_mul #(.AW(EW), .BW(CXW), .LAT(L3)) u_mul_d2 (
      .clk(clk), .en(en), .a($signed(wd[k])), .b($signed(c1[k])), .p(pm2));
    assign pd1[k] = pm1;
    assign pd2[k] = pm2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1 <= DW'($signed(pd1[0])) + DW'($signed(pd1[1])) + DW'($signed(pd1[2]));
      d2 <= DW'($signed(pd2[0])) + DW'($signed(pd2[1])) + DW'($signed(pd2[2]));
    end
  end

  slcm_dly #(.WIDTH(6*EW), .DEPTH(P_D-P_N)) u_dly_e2 (
    .clk(clk), .en(en), .d({e1n, e2n}), .q({e1d, e2d}));

  slcm_dly #(.WIDTH(NNW), .DEPTH(P_P-P_C)) u_dly_nn (
    .clk(clk), .en(en), .d(nn), .q(nnd));

  for (genvar k = 0; k < 3; k++) begin : g_q
    logic signed [PW-1:0] pp1, pp2;
    logic signed [QW-1:0] qq1, qq2;
    slcm_mul #(.AW(DW), .BW(EW), .LAT(L4)) u_mul_p1 (
      .clk(clk), .en(en), .a(d1), .b($signed(e1d[k])), .p(pp1));
    slcm_mul #(.AW(DW), .BW(EW), .LAT(L4)) u_mul_p2 (
      .clk(clk), .en(en), .a(d2), .b($signed(e2d[k])), .p(pp2));
    slcm_div #(.PW(PW), .NW(NNW), .QB(QB)) u_div_1 (
      .clk(clk), .en(en), .p(pp1), .nn(nnd), .q(qq1));
    slcm_div #(.PW(PW), .NW(NNW), .QB(QB)) u_div_2 (
      .clk(clk), .en(en), .p(pp2), .nn(nnd), .q(qq2));
    assign q1[k] = qq1;
    assign q2[k] = qq2;
  end

  slcm_dly #(.WIDTH(3*EW), .DEPTH(P_Q-1)) u_dly_sab (
    .clk(clk), .en(en), .d(sab), .q(sabd));

  slcm_dly #(.WIDTH(1), .DEPTH(P_Q-P_N)) u_dly_deg (
    .clk(clk), .en(en), .d(deg), .q(degd));

  for (genvar k = 0; k < 3; k++) begin : g_mid
    logic signed [SW-1:0] s, h;
    assign s = SW'($signed(sabd[k])) + SW'($signed(q1[k])) + SW'($signed(q2[k]));
    assign h = s >>> 1;
    always_comb begin
      if (degd) begin
        mk[k] = '0;
      end else if (h < LO) begin
        mk[k] = LO[W-1:0];
      end else if (h > HI) begin
        mk[k] = HI[W-1:0];
      end else begin
        mk[k] = h[W-1:0];
      end
    end
  end

  always_comb begin
    res_next.mid_x      = mk[0];
    res_next.mid_y      = mk[1];
    res_next.mid_z      = mk[2];
    res_next.degenerate = degd;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[TL-1:1], hit_valid};
    end
  end

  assign en        = !vld[TL] || (cnt != 2'd2) || mid_ready;
  assign hit_ready = en;
  assign push      = en && vld[TL];
  assign pop       = mid_valid && mid_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (cnt == 2'd2) begin
        buf0 <= buf1;
        if (push) begin
          buf1 <= res;
        end
      end else if (push) begin
        buf0 <= res;
      end
    end else if (push) begin
      if (cnt == 2'd0) begin
        buf0 <= res;
      end else begin
        buf1 <= res;
      end
    end
  end

  assign mid       = buf0;
  assign mid_valid = (cnt != 2'd0);

endmodule

`default_nettype wire

[rtl/slcm_dly.sv]
// ----------------------------------------------------------------------------
// slcm_dly
// Fixed-depth delay line that keeps side data aligned with the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module slcm_dly #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] sh [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (en) begin
      sh[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        sh[i] <= sh[i-1];
      end
    end
  end

  assign q = sh[DEPTH-1];

endmodule

`default_nettype wire

[rtl/slcm_mul.sv]
// ----------------------------------------------------------------------------
// slcm_mul
// Pipelined signed multiplier; one chunk partial product is added per stage until all are summed.
// ----------------------------------------------------------------------------
`default_nettype none

module slcm_mul #(
  parameter int AW  = 21,
  parameter int BW  = 21,
  parameter int LAT = 1
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic signed [AW+BW-1:0] p
);

  localparam int CW = slcm_pkg::CHUNK_W;
  localparam int CA = (AW + CW - 1) / CW;
  localparam int CB = (BW + CW - 1) / CW;
  localparam int NP = CA * CB;
  localparam int NS = (LAT > NP) ? LAT : NP;
  localparam int PW = AW + BW;
  localparam int FW = (CA + CB) * CW;

  logic [CA*CW-1:0] mag_a [0:NS-1];
  logic [CB*CW-1:0] mag_b [0:NS-1];
  logic             sgn   [0:NS];
  logic [PW-1:0]    acc   [0:NS];
  logic [AW-1:0]    abs_a;
  logic [BW-1:0]    abs_b;

  assign abs_a = a[AW-1] ? (~a + 1'b1) : a;
  assign abs_b = b[BW-1] ? (~b + 1'b1) : b;

  always_ff @(posedge clk) begin
    if (en) begin
      mag_a[0] <= (CA*CW)'(abs_a);
      mag_b[0] <= (CB*CW)'(abs_b);
      sgn[0]   <= a[AW-1] ^ b[BW-1];
      acc[0]   <= '0;
    end
  end

  for (genvar k = 1; k <= NS; k++) begin : g_stage
    if (k - 1 < NP) begin : g_pp
      localparam int I = (k - 1) / CB;
      localparam int J = (k - 1) % CB;
      logic [2*CW-1:0] prod;
      logic [FW-1:0]   ppf;
      assign prod = mag_a[k-1][I*CW +: CW] * mag_b[k-1][J*CW +: CW];
      assign ppf  = FW'(prod) << (CW * (I + J));
      always_ff @(posedge clk) begin
        if (en) begin
          acc[k] <= acc[k-1] + ppf[PW-1:0];
        end
      end
    end else begin : g_pass
      always_ff @(posedge clk) begin
        if (en) begin
          acc[k] <= acc[k-1];
        end
      end
    end
    if (k < NS) begin : g_mag
      always_ff @(posedge clk) begin
        if (en) begin
          mag_a[k] <= mag_a[k-1];
          mag_b[k] <= mag_b[k-1];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sgn[k] <= sgn[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= sgn[NS] ? $signed(~acc[NS] + 1'b1) : $signed(acc[NS]);
    end
  end

endmodule

`default_nettype wire

[rtl/slcm_div.sv]
// ----------------------------------------------------------------------------
// slcm_div
// Pipelined restoring divider, one quotient bit per stage, truncating toward
// zero; quotients of magnitude 2^QB or more are clamped to +/-2^QB.
// ----------------------------------------------------------------------------
`default_nettype none

module slcm_div #(
  parameter int PW = 109,
  parameter int NW = 88,
  parameter int QB = 22
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [PW-1:0] p,
  input  logic [NW-1:0]        nn,
  output logic signed [QB+1:0] q
);

  localparam int SH = NW + QB;
  localparam int RW = ((PW > SH) ? PW : SH) + 1;
  localparam logic signed [QB+1:0] CMAX = (QB + 2)'(1) << QB;

  logic [PW-1:0] mag0;
  logic          sgn [0:QB+1];
  logic [NW-1:0] dd  [0:QB+1];
  logic [RW-1:0] rem [1:QB];
  logic [QB-1:0] qv  [1:QB+1];
  logic          ovf [1:QB+1];
  logic signed [QB+1:0] qs;

  always_ff @(posedge clk) begin
    if (en) begin
      mag0   <= p[PW-1] ? (~p + 1'b1) : p;
      sgn[0] <= p[PW-1];
      dd[0]  <= nn;
      rem[1] <= RW'(mag0);
      ovf[1] <= RW'(mag0) >= (RW'(dd[0]) << QB);
      qv[1]  <= '0;
      sgn[1] <= sgn[0];
      dd[1]  <= dd[0];
    end
  end

  for (genvar i = 2; i <= QB + 1; i++) begin : g_bit
    localparam int BIT = QB + 1 - i;
    logic [RW:0] trial;
    assign trial = {1'b0, rem[i-1]} - ((RW + 1)'(dd[i-1]) << BIT);
    always_ff @(posedge clk) begin
      if (en) begin
        sgn[i] <= sgn[i-1];
        dd[i]  <= dd[i-1];
        ovf[i] <= ovf[i-1];
        if (!trial[RW]) begin
          qv[i] <= qv[i-1] | (QB'(1) << BIT);
        end else begin
          qv[i] <= qv[i-1];
        end
      end
    end
    if (i <= QB) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem[i] <= trial[RW] ? rem[i-1] : trial[RW-1:0];
        end
      end
    end
  end

  assign qs = {2'b00, qv[QB+1]};

  always_ff @(posedge clk) begin
    if (en) begin
      if (ovf[QB+1]) begin
        q <= sgn[QB+1] ? -CMAX : CMAX;
      end else begin
        q <= sgn[QB+1] ? -qs : qs;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/slcm_checker.sv]
// ----------------------------------------------------------------------------
// slcm_checker
// Port-level checks for the skew line closest midpoint core.
// ----------------------------------------------------------------------------
`default_nettype none

module slcm_checker (
  input logic           clk,
  input logic           rst,
  input slcm_pkg::in_t  hit,
  input logic           hit_valid,
  input logic           hit_ready,
  input slcm_pkg::out_t mid,
  input logic           mid_valid,
  input logic           mid_ready
);

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    hit_valid && !hit_ready |=> hit_valid && $stable(hit))
    else $error("input item changed while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    mid_valid && !mid_ready |=> mid_valid && $stable(mid))
    else $error("result item changed while stalled");

  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    mid_valid && mid.degenerate |->
      mid.mid_x == '0 && mid.mid_y == '0 && mid.mid_z == '0)
    else $error("degenerate item carries a nonzero point");

  a_reset_empty: assert property (@(posedge clk) rst |=> !mid_valid)
    else $error("result valid right after reset");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !mid_valid |-> hit_ready)
    else $error("input stalled while output buffer is empty");

endmodule

bind skew_line_closest_midpoint_core slcm_checker u_slcm_checker (
  .clk(clk), .rst(rst), .hit(hit), .hit_valid(hit_valid), .hit_ready(hit_ready),
  .mid(mid), .mid_valid(mid_valid), .mid_ready(mid_ready));

`default_nettype wire
